/* rtl/rcfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfb_pkg
// Shared types and constants of the rc channel frame builder.
// ----------------------------------------------------------------------------
package rcfb_pkg;

  localparam int REG_CHANNELS     = 12;
  localparam int FAST_SETUP_COUNT = 50;
  localparam int CH_IDX_W         = $clog2(REG_CHANNELS);

  localparam logic [7:0]  SYNC_BYTE    = 8'hAA;
  localparam logic [7:0]  BIND_FLAGS   = 8'hC0;
  localparam logic [7:0]  POWER_NORMAL = 8'd7;
  localparam logic [7:0]  POWER_RANGE  = 8'd4;
  localparam logic [15:0] EMPTY_SLOT   = 16'hFFFF;
  localparam logic [8:0]  SCALE_HI     = 9'd349;
  localparam logic [4:0]  SCALE_LO     = 5'd13;
  localparam logic [7:0]  FAST_RELOAD  = 8'd2;
  localparam logic [3:0]  SETUP_LAST   = 4'd5;
  localparam logic [3:0]  CHAN_LAST    = 4'd15;
  localparam logic [3:0]  PASS2_BASE   = 4'd7;
  localparam logic [4:0]  MIN_2PASS    = 5'd8;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BIND   = 2'd1,
    MODE_RANGE  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_PROTOCOL_FLAGS = 3'd0,
    REG_SWAP_AETR      = 3'd1,
    REG_CHANNEL_COUNT  = 3'd2,
    REG_MODEL_ID       = 3'd3,
    REG_SETUP_PERIOD   = 3'd4,
    REG_VERSION_MAJOR  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PASS_SETUP = 2'd0,
    PASS_ONE   = 2'd1,
    PASS_TWO   = 2'd2
  } pass_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic emit_byte;  // load next frame byte into output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a byte
    logic last;       // current byte is the frame's final byte
  } dp_sts_t;

  // channel order remap for aetr -> taer
  function automatic logic [3:0] swap_src(input logic [3:0] ch);
    logic [3:0] r;
    unique case (ch)
      4'd0:    r = 4'd2;
      4'd1:    r = 4'd0;
      4'd2:    r = 4'd1;
      default: r = ch;
    endcase
    return r;
  endfunction

endpackage

/* rtl/rcfb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfb_ctrl
// Sequencer: takes input words while idle and steps out one frame byte at a
// time while the output register has room.
// ----------------------------------------------------------------------------
module rcfb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_stall,
  output rcfb_pkg::dp_cmd_t cmd,
  input  rcfb_pkg::dp_sts_t sts
);
  import rcfb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.accept    = 1'b0;
    cmd.emit_byte = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EMIT: begin
        cmd.emit_byte = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/rcfb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfb_dp
// Datapath: configuration registers, channel store, pass and setup counters,
// slot scaling and the output register.
// ----------------------------------------------------------------------------
module rcfb_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [2:0]              cfg_index,
  input  logic [7:0]              cfg_data,
  input  logic                    in_cmd,
  input  logic [3:0]              in_channel_index,
  input  logic signed [12:0]      in_channel_value,
  input  logic [1:0]              in_module_mode,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_frame_byte,
  output logic                    out_last_byte,
  output logic                    out_save_bind_flags,
  input  rcfb_pkg::dp_cmd_t       cmd,
  output rcfb_pkg::dp_sts_t       sts
);
  import rcfb_pkg::*;

  // configuration
  logic [2:0] protocol_flags_r;
  logic       swap_aetr_r;
  logic [4:0] channel_count_r;
  logic [7:0] model_id_r;
  logic [7:0] setup_period_r;
  logic [7:0] version_major_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_flags_r <= '0;
      swap_aetr_r      <= 1'b0;
      channel_count_r  <= 5'd8;
      model_id_r       <= '0;
      setup_period_r   <= 8'd100;
      version_major_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROTOCOL_FLAGS: protocol_flags_r <= cfg_data[2:0];
        REG_SWAP_AETR:      swap_aetr_r      <= cfg_data[0];
        REG_CHANNEL_COUNT:  channel_count_r  <= cfg_data[4:0];
        REG_MODEL_ID:       model_id_r       <= cfg_data;
        REG_SETUP_PERIOD:   setup_period_r   <= cfg_data;
        REG_VERSION_MAJOR:  version_major_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // channel store
  logic signed [12:0] store_r [REG_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_CHANNELS; i++) store_r[i] <= '0;
    end else if (cmd.accept && !in_cmd &&
                 (in_channel_index < 4'(REG_CHANNELS))) begin
      store_r[in_channel_index[CH_IDX_W-1:0]] <= in_channel_value;
    end
  end

  // frame state
  logic [1:0] pass_r;
  logic [7:0] countdown_r;
  logic [5:0] fast_left_r;
  logic [1:0] mode_r;
  logic [3:0] byte_cnt_r;

  logic bind_m, setup_frame;
  assign bind_m      = (mode_r == MODE_BIND);
  assign setup_frame = (pass_r == PASS_SETUP);

  assign sts.last     = setup_frame ? (byte_cnt_r == SETUP_LAST) : (byte_cnt_r == CHAN_LAST);
  assign sts.out_free = !out_valid || !out_stall;

  // slot selection
  logic [2:0]  slot;
  logic [3:0]  ch, src;
  logic [4:0]  lim;
  logic        empty;
  logic signed [12:0] v;

  assign slot = byte_cnt_r[3:1] - 3'd1;
  assign ch   = ((pass_r == PASS_TWO) ? PASS2_BASE : 4'd0) + {1'b0, slot};
  assign lim  = (channel_count_r < 5'(REG_CHANNELS)) ? channel_count_r : 5'(REG_CHANNELS);
  assign empty = ({1'b0, ch} >= lim);
  assign src  = swap_aetr_r ? swap_src(ch) : ch;
  assign v    = (src < 4'(REG_CHANNELS)) ? store_r[src[CH_IDX_W-1:0]] : '0;

  // scaling: floor(v*k / 2^n) plus center, then clamp
  logic [21:0]        prod_hi;
  logic [17:0]        prod_lo;
  logic signed [13:0] p_hi, p_lo;
  logic [10:0]        c_hi;
  logic [9:0]         c_lo;
  logic [15:0]        slot_val;

  assign prod_hi = {{9{v[12]}}, v} * {13'd0, SCALE_HI};
  assign prod_lo = {{5{v[12]}}, v} * {13'd0, SCALE_LO};
  assign p_hi    = $signed(prod_hi[21:9]) + 14'sd1024;
  assign p_lo    = $signed(prod_lo[17:5]) + 14'sd512;

  always_comb begin
    if (p_hi < 0)             c_hi = '0;
    else if (p_hi > 14'sd2047) c_hi = '1;
    else                      c_hi = p_hi[10:0];
    if (p_lo < 0)             c_lo = '0;
    else if (p_lo > 14'sd1023) c_lo = '1;
    else                      c_lo = p_lo[9:0];
  end

  always_comb begin
    if (empty)                  slot_val = EMPTY_SLOT;
    else if (protocol_flags_r[2]) slot_val = {1'b0, ch[3:0], 11'd0} | {5'd0, c_hi};
    else                        slot_val = {2'b0, ch[3:0], 10'd0} | {6'd0, c_lo};
  end

  // next frame byte
  logic [7:0] byte_val;

  always_comb begin
    byte_val = SYNC_BYTE;
    if (setup_frame) begin
      unique case (byte_cnt_r)
        4'd0: byte_val = SYNC_BYTE;
        4'd1: byte_val = 8'd0;
        4'd2: byte_val = bind_m ? BIND_FLAGS : {5'd0, protocol_flags_r};
        4'd3: byte_val = (mode_r == MODE_RANGE) ? POWER_RANGE : POWER_NORMAL;
        4'd4: byte_val = (bind_m && channel_count_r > 5'(REG_CHANNELS)) ?
                         8'(REG_CHANNELS) : {3'd0, channel_count_r};
        default: byte_val = model_id_r;
      endcase
    end else if (byte_cnt_r == 4'd0) begin
      byte_val = SYNC_BYTE;
    end else if (byte_cnt_r == 4'd1) begin
      byte_val = {6'd0, pass_r};
    end else begin
      byte_val = byte_cnt_r[0] ? slot_val[7:0] : slot_val[15:8];
    end
  end

  // pass sequencing at the end of each frame
  logic [1:0] pass_nxt;
  logic [7:0] countdown_nxt, cd_dec;
  logic [5:0] fast_left_nxt;

  assign cd_dec = countdown_r - 8'd1;

  always_comb begin
    pass_nxt      = pass_r;
    countdown_nxt = countdown_r;
    fast_left_nxt = fast_left_r;
    if (setup_frame) begin
      pass_nxt = PASS_ONE;
    end else begin
      pass_nxt = (pass_r == PASS_ONE && channel_count_r >= MIN_2PASS) ? PASS_TWO : PASS_ONE;
      if (bind_m) begin
        pass_nxt = PASS_SETUP;
      end else begin
        countdown_nxt = cd_dec;
        if (cd_dec == 8'd0) begin
          pass_nxt = PASS_SETUP;
          if (version_major_r == 8'd1 && fast_left_r != 6'd0) begin
            fast_left_nxt = fast_left_r - 6'd1;
            countdown_nxt = FAST_RELOAD;
          end else begin
            countdown_nxt = setup_period_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r      <= PASS_ONE;
      countdown_r <= 8'd2;
      fast_left_r <= 6'(FAST_SETUP_COUNT);
      byte_cnt_r  <= '0;
    end else begin
      if (cmd.accept) begin
        byte_cnt_r <= '0;
      end else if (cmd.emit_byte) begin
        byte_cnt_r <= byte_cnt_r + 4'd1;
      end
      if (cmd.emit_byte && sts.last) begin
        pass_r      <= pass_nxt;
        countdown_r <= countdown_nxt;
        fast_left_r <= fast_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) mode_r <= in_module_mode;
  end

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r, out_bind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte_r <= byte_val;
      out_last_r <= sts.last;
      out_bind_r <= setup_frame && bind_m;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_byte      = out_byte_r;
  assign out_last_byte       = out_last_r;
  assign out_save_bind_flags = out_bind_r;

endmodule

/* rtl/rc_channel_frame_builder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_channel_frame_builder_top
// Channel store and radio-module frame builder with byte-wide output.
// ----------------------------------------------------------------------------
// A store word (cmd 0) is taken without producing any output. A frame
// request (cmd 1) is answered with a setup frame of 6 bytes or a channel
// frame of 16 bytes, one byte per cycle while the output is not stalled,
// through a registered output; the byte sequencer handles one frame at a
// time and in_stall stays high until the final byte is loaded. The
// configuration port is always ready; it is to be written only while no
// frame is in progress, a rule the user keeps that the block does not enforce.
module rc_channel_frame_builder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [3:0]         in_channel_index,
  input  logic signed [12:0] in_channel_value,
  input  logic [1:0]         in_module_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte,
  output logic               out_save_bind_flags
);
  import rcfb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rcfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  rcfb_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_cmd              (in_cmd),
    .in_channel_index    (in_channel_index),
    .in_channel_value    (in_channel_value),
    .in_module_mode      (in_module_mode),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_byte      (out_frame_byte),
    .out_last_byte       (out_last_byte),
    .out_save_bind_flags (out_save_bind_flags),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  // a frame request blocks further input until its final byte is loaded
  a_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd) |=> in_stall)
    else $error("frame request did not start a frame");

  // bytes are only loaded while the output register has room
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_byte |-> (!out_valid || !out_stall))
    else $error("output word overwritten while stalled");

  // output words only appear from a frame in progress
  a_valid_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word without a frame in progress");

  // no byte is loaded while the block is taking input
  a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_byte |-> !cmd.accept)
    else $error("byte load and input accept in the same cycle");

endmodule
